// File: hw/rtl/cbb_pkg.sv
// shared types, codes and widths for the circuit breaker backoff controller
package cbb_pkg;

    localparam int TIME_BITS     = 32;
    localparam int INTERVAL_BITS = 24;
    localparam int COUNT_BITS    = 16;
    localparam int JIT_BITS      = 8;

    // operand width of the shared unit, time must be wider than a doubled interval
    localparam int OPW   = TIME_BITS;
    localparam int PRODW = INTERVAL_BITS + 2 * JIT_BITS;
    localparam int RESW  = (PRODW > OPW) ? PRODW : OPW;

    localparam int ADDR_BITS = 5;
    localparam int IDX_BITS  = ADDR_BITS - 2;

    localparam logic [IDX_BITS-1:0] REG_BASE   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_CAP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_PCAP   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_LIMIT  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_JSCALE = 3'd4;

    localparam logic [INTERVAL_BITS-1:0] BASE_RESET  = 24'd1000;
    localparam logic [INTERVAL_BITS-1:0] CAP_RESET   = 24'd60000;
    localparam logic [INTERVAL_BITS-1:0] PCAP_RESET  = 24'd5000;
    localparam logic [COUNT_BITS-1:0]    LIMIT_RESET = 16'd5;
    localparam logic [JIT_BITS-1:0]      JS_RESET    = 8'd0;

    localparam logic [2:0] KIND_ADMIT      = 3'd0;
    localparam logic [2:0] KIND_PROBE_OK   = 3'd1;
    localparam logic [2:0] KIND_PROBE_FAIL = 3'd2;
    localparam logic [2:0] KIND_VERIFY_OK  = 3'd3;
    localparam logic [2:0] KIND_XPORT_FAIL = 3'd4;
    localparam logic [2:0] KIND_INCONCL    = 3'd5;
    localparam logic [2:0] KIND_PRESSURE   = 3'd6;
    localparam logic [2:0] KIND_TIME_CHECK = 3'd7;

    localparam logic [1:0] MODE_CLOSED = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;

    typedef enum logic [1:0] {
        ALU_MIN,
        ALU_MAX,
        ALU_ADD,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        alu_op_t        op;
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] base;
        logic [INTERVAL_BITS-1:0] cap;
        logic [INTERVAL_BITS-1:0] pcap;
        logic [COUNT_BITS-1:0]    limit;
        logic [JIT_BITS-1:0]      jscale;
    } cfg_t;

endpackage

// File: hw/rtl/cbb_regs.sv
// configuration register file behind the apb port
module cbb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cbb_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output cbb_pkg::cfg_t                cfg
);
    import cbb_pkg::*;

    cfg_t                cfg_reg;
    logic                wr_en;
    logic [IDX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base   <= BASE_RESET;
            cfg_reg.cap    <= CAP_RESET;
            cfg_reg.pcap   <= PCAP_RESET;
            cfg_reg.limit  <= LIMIT_RESET;
            cfg_reg.jscale <= JS_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BASE:   cfg_reg.base   <= pwdata[INTERVAL_BITS-1:0];
                REG_CAP:    cfg_reg.cap    <= pwdata[INTERVAL_BITS-1:0];
                REG_PCAP:   cfg_reg.pcap   <= pwdata[INTERVAL_BITS-1:0];
                REG_LIMIT:  cfg_reg.limit  <= pwdata[COUNT_BITS-1:0];
                REG_JSCALE: cfg_reg.jscale <= pwdata[JIT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BASE:   prdata = 32'(cfg_reg.base);
            REG_CAP:    prdata = 32'(cfg_reg.cap);
            REG_PCAP:   prdata = 32'(cfg_reg.pcap);
            REG_LIMIT:  prdata = 32'(cfg_reg.limit);
            REG_JSCALE: prdata = 32'(cfg_reg.jscale);
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/cbb_alu.sv
// shared min/max, saturating add and multiply unit with registered result
module cbb_alu (
    input  logic                    clk,
    input  cbb_pkg::alu_req_t       req,
    output logic [cbb_pkg::RESW-1:0] res
);
    import cbb_pkg::*;

    logic [RESW-1:0] res_reg;
    logic [RESW-1:0] res_next;
    logic [OPW:0]    sum;
    logic [PRODW-1:0] prod;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign prod = req.a[INTERVAL_BITS-1:0] * req.b[2*JIT_BITS-1:0];

    always_comb
    begin
        case (req.op)
            ALU_MIN: res_next = RESW'((req.a < req.b) ? req.a : req.b);
            ALU_MAX: res_next = RESW'((req.a > req.b) ? req.a : req.b);
            // saturates at the all-ones time value
            ALU_ADD: res_next = RESW'(sum[OPW] ? {OPW{1'b1}} : sum[OPW-1:0]);
            ALU_MUL: res_next = RESW'(prod);
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/cbb_seq.sv
// breaker state and the sequencer that drives the shared unit
module cbb_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cbb_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       kind,
    input  logic [cbb_pkg::TIME_BITS-1:0]    now_ms,
    input  logic [cbb_pkg::JIT_BITS-1:0]     jitter_sample,
    input  logic                             pressure_flag,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             admitted,
    output logic                             probe_due,
    output logic [1:0]                       breaker_mode,
    output logic [cbb_pkg::TIME_BITS-1:0]    next_probe_time,
    output cbb_pkg::alu_req_t                alu_req,
    input  logic [cbb_pkg::RESW-1:0]         alu_res
);
    import cbb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAXS,
        ST_DBL,
        ST_ACAP,
        ST_BASE,
        ST_JMUL,
        ST_BMUL,
        ST_DADD,
        ST_CLAMP,
        ST_TADD,
        ST_PCAP,
        ST_PADD,
        ST_PMIN,
        ST_STORE,
        ST_DONE
    } state_t;

    state_t                   state_reg;
    logic [1:0]               mode_reg;
    logic                     token_reg;
    logic [COUNT_BITS-1:0]    fc_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [TIME_BITS-1:0]     ptime_reg;
    logic                     press_reg;

    logic [2:0]               kind_reg;
    logic [TIME_BITS-1:0]     now_reg;
    logic [JIT_BITS-1:0]      jit_reg;
    logic                     adm_reg;
    logic                     dbl_reg;
    logic [INTERVAL_BITS-1:0] acap_reg;
    logic [INTERVAL_BITS-1:0] basew_reg;

    logic                     out_valid_reg;
    logic                     out_adm_reg;
    logic                     out_due_reg;
    logic [1:0]               out_mode_reg;
    logic [TIME_BITS-1:0]     out_time_reg;

    logic                     accept;
    logic                     out_free;
    logic [COUNT_BITS-1:0]    fc_next;
    logic [INTERVAL_BITS-1:0] dbl_src;
    logic                     start_adm;
    logic                     start_dbl;
    state_t                   start_state;

    assign in_ready        = (state_reg == ST_IDLE);
    assign accept          = in_valid && in_ready;
    assign out_free        = !out_valid_reg || out_ready;
    assign fc_next         = (fc_reg == {COUNT_BITS{1'b1}}) ? fc_reg : fc_reg + 1'b1;
    assign dbl_src         = (kind_reg == KIND_PROBE_FAIL) ? interval_reg
                                                           : alu_res[INTERVAL_BITS-1:0];
    assign out_valid       = out_valid_reg;
    assign admitted        = out_adm_reg;
    assign probe_due       = out_due_reg;
    assign breaker_mode    = out_mode_reg;
    assign next_probe_time = out_time_reg;

    // first step of the sequence for an accepted event
    always_comb
    begin
        start_adm   = (kind == KIND_ADMIT) &&
                      ((mode_reg == MODE_CLOSED) || (mode_reg == MODE_HALF && token_reg));
        start_dbl   = 1'b0;
        start_state = ST_DONE;
        case (kind)
            KIND_PROBE_FAIL:
            begin
                if (mode_reg == MODE_OPEN)
                begin
                    start_dbl   = 1'b1;
                    start_state = ST_DBL;
                end
            end
            KIND_XPORT_FAIL:
            begin
                if (mode_reg == MODE_HALF)
                begin
                    start_dbl   = 1'b1;
                    start_state = ST_MAXS;
                end
                else if (mode_reg == MODE_CLOSED && fc_next >= cfg.limit)
                begin
                    start_state = ST_ACAP;
                end
            end
            KIND_PRESSURE:
            begin
                if (!press_reg && pressure_flag && mode_reg == MODE_OPEN)
                begin
                    start_state = ST_PCAP;
                end
            end
            default: ;
        endcase
    end

    // operand selection for the shared unit, result shows up one state later
    always_comb
    begin
        alu_req.op = ALU_MIN;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            ST_MAXS:
            begin
                alu_req.op = ALU_MAX;
                alu_req.a  = OPW'(interval_reg);
                alu_req.b  = OPW'(cfg.base);
            end
            ST_DBL:
            begin
                alu_req.a = OPW'({dbl_src, 1'b0});
                alu_req.b = OPW'(cfg.cap);
            end
            ST_ACAP, ST_PCAP:
            begin
                alu_req.a = OPW'(cfg.cap);
                alu_req.b = (press_reg || state_reg == ST_PCAP) ? OPW'(cfg.pcap)
                                                                : OPW'(cfg.cap);
            end
            ST_BASE:
            begin
                alu_req.a = OPW'(interval_reg);
                alu_req.b = alu_res[OPW-1:0];
            end
            ST_JMUL:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = OPW'(jit_reg);
                alu_req.b  = OPW'(cfg.jscale);
            end
            ST_BMUL:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = OPW'(basew_reg);
                alu_req.b  = OPW'(alu_res[2*JIT_BITS-1:0]);
            end
            ST_DADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = OPW'(basew_reg);
                alu_req.b  = OPW'(alu_res[PRODW-1:2*JIT_BITS]);
            end
            ST_CLAMP:
            begin
                alu_req.a = alu_res[OPW-1:0];
                alu_req.b = press_reg ? OPW'(acap_reg) : alu_res[OPW-1:0];
            end
            ST_TADD, ST_PADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = now_reg;
                alu_req.b  = alu_res[OPW-1:0];
            end
            ST_PMIN:
            begin
                alu_req.a = ptime_reg;
                alu_req.b = alu_res[OPW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_CLOSED;
            token_reg     <= 1'b0;
            fc_reg        <= '0;
            interval_reg  <= BASE_RESET;
            ptime_reg     <= '0;
            press_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_TIME_CHECK;
            now_reg       <= '0;
            jit_reg       <= '0;
            adm_reg       <= 1'b0;
            dbl_reg       <= 1'b0;
            acap_reg      <= '0;
            basew_reg     <= '0;
            out_adm_reg   <= 1'b0;
            out_due_reg   <= 1'b0;
            out_mode_reg  <= MODE_CLOSED;
            out_time_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= kind;
                        now_reg   <= now_ms;
                        jit_reg   <= jitter_sample;
                        adm_reg   <= start_adm;
                        dbl_reg   <= start_dbl;
                        state_reg <= start_state;
                        case (kind)
                            KIND_ADMIT:
                            begin
                                if (mode_reg == MODE_HALF && token_reg)
                                begin
                                    token_reg <= 1'b0;
                                end
                            end
                            KIND_PROBE_OK:
                            begin
                                if (mode_reg == MODE_OPEN)
                                begin
                                    mode_reg  <= MODE_HALF;
                                    token_reg <= 1'b1;
                                end
                            end
                            KIND_VERIFY_OK:
                            begin
                                mode_reg     <= MODE_CLOSED;
                                fc_reg       <= '0;
                                interval_reg <= cfg.base;
                                token_reg    <= 1'b0;
                            end
                            KIND_XPORT_FAIL:
                            begin
                                if (mode_reg == MODE_HALF)
                                begin
                                    // trip with a doubled interval, never below base
                                    mode_reg  <= MODE_OPEN;
                                    token_reg <= 1'b0;
                                end
                                else if (mode_reg == MODE_CLOSED)
                                begin
                                    fc_reg <= fc_next;
                                    if (fc_next >= cfg.limit)
                                    begin
                                        interval_reg <= cfg.base;
                                        mode_reg     <= MODE_OPEN;
                                        token_reg    <= 1'b0;
                                    end
                                end
                            end
                            KIND_INCONCL:
                            begin
                                fc_reg <= '0;
                                if (mode_reg == MODE_HALF)
                                begin
                                    token_reg <= 1'b1;
                                end
                            end
                            KIND_PRESSURE:
                            begin
                                press_reg <= pressure_flag;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MAXS:  state_reg <= ST_DBL;
                ST_DBL:   state_reg <= ST_ACAP;
                ST_ACAP:
                begin
                    if (dbl_reg)
                    begin
                        interval_reg <= alu_res[INTERVAL_BITS-1:0];
                    end
                    state_reg <= ST_BASE;
                end
                ST_BASE:
                begin
                    acap_reg  <= alu_res[INTERVAL_BITS-1:0];
                    state_reg <= ST_JMUL;
                end
                ST_JMUL:
                begin
                    basew_reg <= alu_res[INTERVAL_BITS-1:0];
                    state_reg <= ST_BMUL;
                end
                ST_BMUL:  state_reg <= ST_DADD;
                ST_DADD:  state_reg <= ST_CLAMP;
                ST_CLAMP: state_reg <= ST_TADD;
                ST_TADD:  state_reg <= ST_STORE;
                ST_PCAP:  state_reg <= ST_PADD;
                ST_PADD:  state_reg <= ST_PMIN;
                ST_PMIN:  state_reg <= ST_STORE;
                ST_STORE:
                begin
                    ptime_reg <= alu_res[TIME_BITS-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_adm_reg   <= adm_reg;
                        out_due_reg   <= (mode_reg == MODE_OPEN) && (now_reg >= ptime_reg);
                        out_mode_reg  <= mode_reg;
                        out_time_reg  <= ptime_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_token_half: assert property (@(posedge clk) disable iff (!rst_n)
        token_reg |-> mode_reg == MODE_HALF)
        else $error("admission token held outside half-open");

    a_store_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STORE |-> mode_reg == MODE_OPEN)
        else $error("probe time written while breaker not open");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new event taken while one is in flight");

    a_adm_closed_half: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && adm_reg) |-> mode_reg != MODE_OPEN)
        else $error("admission granted while open");

endmodule

// File: hw/rtl/circuit_breaker_backoff_controller.sv
// Circuit breaker with exponential probe backoff: closed, open and half-open modes.
// Each event on the input channel yields exactly one result transfer. Admit, probe ok,
// verify ok, inconclusive, time check and transport failures that do not trip go
// straight to the result register; a trip from closed, a failed probe and a trip
// from half-open run the probe scheduler, and so does a pressure rise while open.
// Each step uses the single shared min/max/add/multiply unit, which the sequencer
// uses once per cycle with a registered result. The input is not ready while an
// event is in work; a finished result waits in the output register, and the next
// event is taken and worked meanwhile but its result is held until that register
// is free. Configuration is written over the apb port at byte address 4*index.
module circuit_breaker_backoff_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbb_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       kind,
    input  logic [cbb_pkg::TIME_BITS-1:0]    now_ms,
    input  logic [cbb_pkg::JIT_BITS-1:0]     jitter_sample,
    input  logic                             pressure_flag,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             admitted,
    output logic                             probe_due,
    output logic [1:0]                       breaker_mode,
    output logic [cbb_pkg::TIME_BITS-1:0]    next_probe_time
);
    import cbb_pkg::*;

    cfg_t            cfg;
    alu_req_t        alu_req;
    logic [RESW-1:0] alu_res;

    cbb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbb_alu u_alu (
        .clk (clk),
        .req (alu_req),
        .res (alu_res)
    );

    cbb_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .now_ms          (now_ms),
        .jitter_sample   (jitter_sample),
        .pressure_flag   (pressure_flag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .admitted        (admitted),
        .probe_due       (probe_due),
        .breaker_mode    (breaker_mode),
        .next_probe_time (next_probe_time),
        .alu_req         (alu_req),
        .alu_res         (alu_res)
    );

endmodule
